>>> design/cbs_pkg.sv
// Shared types and codes for the coil bit store.
// Holds request kinds, field widths and stream payload widths.
// No dependencies.
package cbs_pkg;

    // Field widths of one request and of the coil count register
    localparam int KIND_W  = 3;
    localparam int START_W = 9;
    localparam int LEN_W   = 10;
    localparam int SRC_W   = 8;
    localparam int COUNT_W = 10;

    // Stream payload widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Request kinds
    localparam kind_t KIND_RD_RANGE  = 3'd0;
    localparam kind_t KIND_WR_RANGE  = 3'd1;
    localparam kind_t KIND_RD_SINGLE = 3'd2;
    localparam kind_t KIND_WR_SINGLE = 3'd3;
    localparam kind_t KIND_FILL      = 3'd4;

    // Result status codes
    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

endpackage

>>> design/coil_bit_store.sv
// Coil bit store. A range or single read runs RD_WAIT, RD_LO, RD_HWAIT, RD_HI, EMIT for its
// first byte and RD_HWAIT, RD_HI, EMIT for each further byte: one byte memory read plus one
// output load, with EMIT waiting while the output is held. A write runs WR_WAIT, WR_LO (and
// WR_HWAIT, WR_HI across a byte boundary) and EMIT; a rejected or empty request goes straight
// to EMIT; a fill writes each store byte in FILL; one request is in work at a time.
// Reset clears control state and the per-byte valid flags, so the store reads all zero.
module coil_bit_store #(
    parameter int MAX_COILS = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request: start_coil[8:0], coil_length[18:9], first_of_run[19],
    //          source_byte[27:20], bit_value[28], zero fill above
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cbs_pkg::IN_DATA_W-1:0]   s_tdata,
    input  cbs_pkg::kind_t                  s_tuser,   // kind[2:0]
    input  logic                            s_tlast,   // run_end
    // result: packed_byte[7:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cbs_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tuser,   // status[0]
    output logic                            m_tlast,   // last_result
    // coil_count register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  cbs_pkg::count_t                 cfg_data
);
    import cbs_pkg::*;

    localparam int STORE_BYTES = (MAX_COILS + 7) / 8;
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int RW = AW + 1;
    localparam int CW = (AW + 4 > 11) ? AW + 4 : 11;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD_WAIT  = 4'd1;
    localparam logic [3:0] S_RD_LO    = 4'd2;
    localparam logic [3:0] S_RD_HWAIT = 4'd3;
    localparam logic [3:0] S_RD_HI    = 4'd4;
    localparam logic [3:0] S_WR_WAIT  = 4'd5;
    localparam logic [3:0] S_WR_LO    = 4'd6;
    localparam logic [3:0] S_WR_HWAIT = 4'd7;
    localparam logic [3:0] S_WR_HI    = 4'd8;
    localparam logic [3:0] S_FILL     = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    // Byte memory and per-byte valid flags
    logic [7:0]             mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] row_valid_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_ok_reg;

    logic [3:0]         state_reg;
    logic [RW-1:0]      row_reg;
    logic [2:0]         sh_reg;
    logic [LEN_W-1:0]   rem_reg;
    logic [7:0]         lo_reg;
    logic [15:0]        mask16_reg;
    logic [15:0]        data16_reg;
    logic               fill_val_reg;
    logic [7:0]         res_byte_reg;
    logic               res_status_reg;
    logic               res_last_reg;
    count_t             coil_count_reg;
    logic [LEN_W-1:0]   wr_pos_reg;
    logic [LEN_W-1:0]   wr_rem_reg;
    logic               wr_ok_reg;
    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg;
    logic               m_tuser_reg;
    logic               m_tlast_reg;

    // Request fields
    kind_t              kind;
    logic [START_W-1:0] start_coil;
    logic [LEN_W-1:0]   coil_length;
    logic               first_of_run;
    logic [SRC_W-1:0]   source_byte;
    logic               bit_value;
    logic               run_end;

    assign kind         = s_tuser;
    assign start_coil   = s_tdata[8:0];
    assign coil_length  = s_tdata[18:9];
    assign first_of_run = s_tdata[19];
    assign source_byte  = s_tdata[27:20];
    assign bit_value    = s_tdata[28];
    assign run_end      = s_tlast;

    logic [COUNT_W-1:0] size;
    logic [LEN_W-1:0]   start_ext;
    logic               start_in;
    logic [LEN_W-1:0]   rd_len;
    logic               rd_bad;
    logic               run_ok_cur;
    logic [LEN_W-1:0]   run_pos_cur;
    logic [LEN_W-1:0]   run_rem_cur;
    logic [3:0]         run_n;
    logic [7:0]         run_en;
    logic [LEN_W-1:0]   op_pos;
    logic [7:0]         op_en;
    logic [7:0]         op_src;
    logic               row_in_store;
    logic [AW-1:0]      row_addr;
    logic [7:0]         rd_byte;
    logic [15:0]        rd_win;
    logic [7:0]         rd_mask;
    logic [7:0]         cur_mask;
    logic [7:0]         cur_data;
    logic [7:0]         merged;
    logic [7:0]         fill_byte;
    logic               mem_we;
    logic [7:0]         mem_wdata;
    logic               slot_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;
    assign slot_free = !m_tvalid_reg || m_tready;

    // Clamp the coil count to 1..MAX_COILS
    always_comb
    begin
        if (coil_count_reg == '0)
            size = COUNT_W'(1);
        else if (32'(coil_count_reg) > MAX_COILS)
            size = COUNT_W'(MAX_COILS);
        else
            size = coil_count_reg;
    end

    // Decode range reads, the write run and single writes at request time
    always_comb
    begin
        start_ext = {1'b0, start_coil};
        start_in  = (start_ext < size);
        if (coil_length == '0)
            rd_len = start_in ? (size - start_ext) : '0;
        else
            rd_len = coil_length;
        rd_bad = (rd_len == '0)
              || (({1'b0, start_ext} + {1'b0, rd_len}) > {1'b0, size});

        if (first_of_run)
        begin
            run_ok_cur  = (coil_length != '0)
                       && (({1'b0, start_ext} + {1'b0, coil_length}) <= {1'b0, size});
            run_pos_cur = start_ext;
            run_rem_cur = run_ok_cur ? coil_length : '0;
        end
        else
        begin
            run_ok_cur  = wr_ok_reg;
            run_pos_cur = wr_pos_reg;
            run_rem_cur = wr_rem_reg;
        end

        if (!run_ok_cur)
            run_n = 4'd0;
        else if (run_rem_cur >= LEN_W'(8))
            run_n = 4'd8;
        else
            run_n = run_rem_cur[3:0];

        for (int j = 0; j < 8; j++)
        begin
            run_en[j] = (4'(j) < run_n)
                     && (({1'b0, run_pos_cur} + 11'(j)) < {1'b0, size});
        end

        if (kind == KIND_WR_SINGLE)
        begin
            op_pos = start_ext;
            op_en  = {7'b0, start_in};
            op_src = {7'b0, bit_value};
        end
        else
        begin
            op_pos = run_pos_cur;
            op_en  = run_en;
            op_src = source_byte;
        end
    end

    // Shared byte unit: read alignment, write merge and fill pattern
    always_comb
    begin
        row_in_store = (row_reg < RW'(STORE_BYTES));
        row_addr     = row_reg[AW-1:0];
        rd_byte      = rd_ok_reg ? rd_data_reg : 8'h00;
        rd_win       = {rd_byte, lo_reg} >> sh_reg;
        rd_mask      = (rem_reg >= LEN_W'(8)) ? 8'hFF : ((8'h01 << rem_reg[2:0]) - 8'h01);
        cur_mask     = (state_reg == S_WR_HI) ? mask16_reg[15:8] : mask16_reg[7:0];
        cur_data     = (state_reg == S_WR_HI) ? data16_reg[15:8] : data16_reg[7:0];
        merged       = (rd_byte & ~cur_mask) | cur_data;
        for (int b = 0; b < 8; b++)
        begin
            fill_byte[b] = (({CW'(row_reg), 3'b000} + (CW + 3)'(b)) < (CW + 3)'(size))
                         ? fill_val_reg : 1'b0;
        end
        mem_we    = row_in_store
                 && ((state_reg == S_WR_LO) || (state_reg == S_WR_HI)
                     || (state_reg == S_FILL));
        mem_wdata = (state_reg == S_FILL) ? fill_byte : merged;
    end

    // Byte memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[row_addr] <= mem_wdata;
        rd_data_reg <= mem[row_addr];
    end

    // Valid flags: a byte never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (mem_we)
                row_valid_reg[row_addr] <= 1'b1;
            rd_ok_reg <= row_in_store && row_valid_reg[row_addr];
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coil_count_reg <= COUNT_W'(512);
        else if (cfg_valid)
            coil_count_reg <= cfg_data;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            row_reg        <= '0;
            sh_reg         <= '0;
            rem_reg        <= '0;
            lo_reg         <= '0;
            mask16_reg     <= '0;
            data16_reg     <= '0;
            fill_val_reg   <= 1'b0;
            res_byte_reg   <= '0;
            res_status_reg <= STATUS_DONE;
            res_last_reg   <= 1'b0;
            wr_pos_reg     <= '0;
            wr_rem_reg     <= '0;
            wr_ok_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= 1'b0;
            m_tlast_reg    <= 1'b0;
        end
        else
        begin
            // Drop the result once taken; the emit state reloads it on its own
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        // Default: single result, no data
                        res_byte_reg   <= 8'h00;
                        res_status_reg <= STATUS_REJECTED;
                        res_last_reg   <= 1'b1;
                        state_reg      <= S_EMIT;
                        unique case (kind) inside
                            KIND_RD_RANGE, KIND_RD_SINGLE:
                            begin
                                if ((kind == KIND_RD_RANGE) ? !rd_bad : start_in)
                                begin
                                    row_reg   <= RW'(start_ext >> 3);
                                    sh_reg    <= start_coil[2:0];
                                    rem_reg   <= (kind == KIND_RD_RANGE) ? rd_len : LEN_W'(1);
                                    state_reg <= S_RD_WAIT;
                                end
                            end
                            KIND_WR_RANGE, KIND_WR_SINGLE:
                            begin
                                if (kind == KIND_WR_RANGE)
                                begin
                                    // Advance the write run
                                    res_status_reg <= run_ok_cur ? STATUS_DONE : STATUS_REJECTED;
                                    wr_ok_reg  <= run_end ? 1'b0 : run_ok_cur;
                                    wr_pos_reg <= run_pos_cur + LEN_W'(run_n);
                                    wr_rem_reg <= run_end ? '0 : (run_rem_cur - LEN_W'(run_n));
                                end
                                else
                                begin
                                    res_status_reg <= start_in ? STATUS_DONE : STATUS_REJECTED;
                                end
                                if (op_en != 8'h00)
                                begin
                                    row_reg    <= RW'(op_pos >> 3);
                                    mask16_reg <= {8'h00, op_en} << op_pos[2:0];
                                    data16_reg <= {8'h00, op_src & op_en} << op_pos[2:0];
                                    state_reg  <= S_WR_WAIT;
                                end
                            end
                            KIND_FILL:
                            begin
                                row_reg        <= '0;
                                fill_val_reg   <= bit_value;
                                res_status_reg <= STATUS_DONE;
                                state_reg      <= S_FILL;
                            end
                            default:
                            begin
                                res_status_reg <= STATUS_REJECTED;
                            end
                        endcase
                    end
                end
                S_RD_WAIT:
                begin
                    state_reg <= S_RD_LO;
                end
                S_RD_LO:
                begin
                    lo_reg    <= rd_byte;
                    row_reg   <= row_reg + RW'(1);
                    state_reg <= S_RD_HWAIT;
                end
                S_RD_HWAIT:
                begin
                    state_reg <= S_RD_HI;
                end
                S_RD_HI:
                begin
                    res_byte_reg   <= rd_win[7:0] & rd_mask;
                    res_status_reg <= STATUS_DONE;
                    res_last_reg   <= (rem_reg <= LEN_W'(8));
                    lo_reg         <= rd_byte;
                    state_reg      <= S_EMIT;
                end
                S_WR_WAIT:
                begin
                    state_reg <= S_WR_LO;
                end
                S_WR_LO:
                begin
                    row_reg   <= row_reg + RW'(1);
                    state_reg <= (mask16_reg[15:8] != 8'h00) ? S_WR_HWAIT : S_EMIT;
                end
                S_WR_HWAIT:
                begin
                    state_reg <= S_WR_HI;
                end
                S_WR_HI:
                begin
                    state_reg <= S_EMIT;
                end
                S_FILL:
                begin
                    row_reg <= row_reg + RW'(1);
                    if (row_reg == RW'(STORE_BYTES - 1))
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // Hold until the output register is free
                    if (slot_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_byte_reg;
                        m_tuser_reg  <= res_status_reg;
                        m_tlast_reg  <= res_last_reg;
                        if (res_last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            rem_reg   <= rem_reg - LEN_W'(8);
                            row_reg   <= row_reg + RW'(1);
                            state_reg <= S_RD_HWAIT;
                        end
                    end
                    else if (m_tvalid_reg && m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
